/* sv/agrc_pkg.sv */
`timescale 1ns / 1ps

package agrc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int VOL_W      = 7;
    localparam int GAIN_W     = 26;
    localparam int TARGET_W   = 25;
    localparam int OPND_W     = 27;
    localparam int PROD_W     = 2 * OPND_W;

    localparam int VOL_MAX    = 100;
    localparam longint GAIN_ONE   = 64'd16777216;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 26'd4194304;
    localparam int RAMP_COEF  = 1049;
    localparam int RAMP_SHIFT = 20;
    localparam int PROD_SHIFT = 24;
    localparam int CLIP_LIMIT = 7969178;

    typedef logic [TARGET_W-1:0] target_t;
    typedef target_t target_tab_t [0:VOL_MAX];

    // shared multiplier control
    typedef struct packed {
        logic load;
    } mul_ctrl_t;

    // gain targets, volume percent to Q1.24 rounded to nearest
    function automatic target_tab_t build_target_tab();
        target_tab_t tab;
        for (int i = 0; i <= VOL_MAX; i++) begin
            tab[i] = TARGET_W'((64'(i) * GAIN_ONE + 64'd50) / 64'd100);
        end
        return tab;
    endfunction

    localparam target_tab_t TARGET_TAB = build_target_tab();

endpackage

/* sv/agrc_mul.sv */
`timescale 1ns / 1ps

module agrc_mul
    import agrc_pkg::*;
(
    input  logic                     aclk,
    input  mul_ctrl_t                ctrl,
    input  logic signed [OPND_W-1:0] opnd_a,
    input  logic signed [OPND_W-1:0] opnd_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            prod_reg <= opnd_a * opnd_b;
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/audio_gain_ramp_clipper_top.sv */
`timescale 1ns / 1ps

// Gain smoother and clipper for a 24-bit PCM stream.
// Input channel s_*: one sample with play flag and volume (0..100, larger
// values saturate to 100) per item. Result channel m_*: one scaled sample
// per item, clamped to +/-0.95 full scale.
// While playing, the kept Q2.24 gain first moves about 0.1 percent of the
// way toward volume/100, then scales the sample. While paused the result is
// silence and the gain holds.
// A single 27x27 signed multiplier does both products under a small
// sequencer: ramp product, gain update, sample product, clip.
// A playing item passes the ramp, gain and scale steps before the clip step
// writes it; a paused item goes straight to that step. s_ready is high only
// when the sequencer is idle, so an item is taken after the last has left it.
// The result sits in an output register: a new item is taken while it
// waits, but the sequencer holds before the last step until m_ready frees
// the register, and s_ready stays low meanwhile.
// Reset (aresetn low, synchronous) sets the gain to 0.25 and drops m_valid.

module audio_gain_ramp_clipper_top
    import agrc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       s_play_enable,
    input  logic [VOL_W-1:0]           s_volume_level,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP,
        S_GAIN,
        S_SCALE,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [GAIN_W-1:0]           gain_reg, gain_next;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    target_t                     target_reg;
    logic                        mute_reg;
    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  out_reg, out_next;

    logic                        accept;
    logic [VOL_W-1:0]            vol_sat;
    mul_ctrl_t                   mul_ctrl;
    logic signed [OPND_W-1:0]    opnd_a, opnd_b;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [PROD_W-RAMP_SHIFT-1:0] step;
    logic signed [PROD_W-RAMP_SHIFT:0]   gain_sum;
    logic signed [PROD_W-PROD_SHIFT-1:0] scaled;
    logic                        out_free;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_sample_out = out_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign vol_sat = (s_volume_level > VOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX) : s_volume_level;

    // operand selection for the shared multiplier
    always_comb begin
        mul_ctrl.load = 1'b0;
        opnd_a        = '0;
        opnd_b        = '0;
        case (state_reg)
            S_RAMP: begin
                mul_ctrl.load = 1'b1;
                opnd_a = $signed({2'b00, target_reg}) - $signed({1'b0, gain_reg});
                opnd_b = OPND_W'(RAMP_COEF);
            end
            S_SCALE: begin
                mul_ctrl.load = 1'b1;
                opnd_a = OPND_W'(sample_reg);
                opnd_b = $signed({1'b0, gain_reg});
            end
            default: begin
                mul_ctrl.load = 1'b0;
            end
        endcase
    end

    agrc_mul u_mul (
        .aclk   (aclk),
        .ctrl   (mul_ctrl),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .prod   (prod)
    );

    // round to nearest, ties up: add half then floor shift
    always_comb begin
        if (state_reg == S_GAIN) begin
            prod_rnd = prod + (PROD_W'(1) <<< (RAMP_SHIFT - 1));
        end else begin
            prod_rnd = prod + (PROD_W'(1) <<< (PROD_SHIFT - 1));
        end
    end

    assign step     = prod_rnd[PROD_W-1:RAMP_SHIFT];
    assign gain_sum = $signed({{(PROD_W-RAMP_SHIFT-GAIN_W+1){1'b0}}, gain_reg})
                      + (PROD_W-RAMP_SHIFT+1)'(step);
    assign scaled   = prod_rnd[PROD_W-1:PROD_SHIFT];

    always_comb begin
        state_next   = state_reg;
        gain_next    = gain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = s_play_enable ? S_RAMP : S_DONE;
                end
            end
            S_RAMP: begin
                state_next = S_GAIN;
            end
            S_GAIN: begin
                if (gain_sum < 0) begin
                    gain_next = '0;
                end else if (gain_sum > (PROD_W-RAMP_SHIFT+1)'({GAIN_W{1'b1}})) begin
                    gain_next = '1;
                end else begin
                    gain_next = gain_sum[GAIN_W-1:0];
                end
                state_next = S_SCALE;
            end
            S_SCALE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (mute_reg) begin
                        out_next = '0;
                    end else if (scaled > (PROD_W-PROD_SHIFT)'(CLIP_LIMIT)) begin
                        out_next = SAMPLE_W'(CLIP_LIMIT);
                    end else if (scaled < -(PROD_W-PROD_SHIFT)'(CLIP_LIMIT)) begin
                        out_next = -SAMPLE_W'(CLIP_LIMIT);
                    end else begin
                        out_next = scaled[SAMPLE_W-1:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            gain_reg    <= GAIN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
        if (accept) begin
            sample_reg <= s_sample_in;
            target_reg <= TARGET_TAB[vol_sat];
            mute_reg   <= !s_play_enable;
        end
    end

endmodule

/* verif/audio_gain_ramp_clipper_top_test.sv */
`timescale 1ns / 1ps

module audio_gain_ramp_clipper_top_test;

    import agrc_pkg::*;

    localparam int     LOUD_ITEMS  = 900;
    localparam int     MIXED_ITEMS = 280;
    localparam int     HOLD_CYCLES = 300;
    localparam int     DRAIN_WAIT  = 12;
    localparam longint GAIN_TOP    = (longint'(1) << GAIN_W) - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       play;
        logic [VOL_W-1:0]           vol;
        logic                       known;
        logic signed [SAMPLE_W-1:0] want;
    } dir_row_t;

    typedef struct {
        int                         idx;
        logic signed [SAMPLE_W-1:0] smp;
    } sample_exp_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic                       s_play_enable;
    logic [VOL_W-1:0]           s_volume_level;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;

    // known rows rely on the gain sitting at its reset value of one quarter
    dir_row_t dir_tab [0:21] = '{
        '{ 8388607, 1'b0, 100, 1'b1, 0},
        '{-8388608, 1'b0, 127, 1'b1, 0},
        '{ 8388607, 1'b1,  25, 1'b1, 2097152},
        '{-8388608, 1'b1,  25, 1'b1, -2097152},
        '{       0, 1'b1,  25, 1'b1, 0},
        '{ 8388607, 1'b1, 100, 1'b0, 0},
        '{-8388608, 1'b1, 127, 1'b0, 0},
        '{       1, 1'b1, 101, 1'b0, 0},
        '{      -1, 1'b1,   0, 1'b0, 0},
        '{ 8388607, 1'b1,   0, 1'b0, 0},
        '{      -1, 1'b0, 127, 1'b1, 0},
        '{ 8388607, 1'b1,   0, 1'b0, 0},
        '{ 5592405, 1'b1,  85, 1'b0, 0},
        '{-5592406, 1'b1,  42, 1'b0, 0},
        '{ 4194304, 1'b1,  50, 1'b0, 0},
        '{-4194304, 1'b1,  64, 1'b0, 0},
        '{ 8388607, 1'b1, 100, 1'b0, 0},
        '{-8388608, 1'b1, 100, 1'b0, 0},
        '{       0, 1'b0,   0, 1'b1, 0},
        '{   12345, 1'b1,  99, 1'b0, 0},
        '{-7969178, 1'b1, 100, 1'b0, 0},
        '{ 7969178, 1'b1, 127, 1'b0, 0}
    };

    sample_exp_t pending_samples [$];
    sample_exp_t head_exp;
    longint      gain_q = longint'(GAIN_RESET);
    longint      peak_gain = longint'(GAIN_RESET);
    bit          steady;
    bit          hold_req;
    int          hold_left;
    int          errors;
    int          items_sent;
    int          paused_items;
    int          saturated_vol;
    int          results_seen;
    int          clipped_results;

    audio_gain_ramp_clipper_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .s_play_enable  (s_play_enable),
        .s_volume_level (s_volume_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out)
    );

    always #6 aclk = ~aclk;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // one-pole gain step toward volume/100, then scale and clamp the sample; silence while paused
    function automatic logic signed [SAMPLE_W-1:0] gain_scaled_sample(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       play,
        input logic [VOL_W-1:0]           vol
    );
        longint vol_sat;
        longint target;
        longint step;
        longint g;
        longint prod;
        if (!play) begin
            return '0;
        end
        vol_sat = (vol > VOL_MAX) ? longint'(VOL_MAX) : longint'(vol);
        target = (vol_sat * GAIN_ONE + 50) / 100;
        g = gain_q;
        step = ((target - g) * RAMP_COEF + (longint'(1) <<< (RAMP_SHIFT - 1))) >>> RAMP_SHIFT;
        g = g + step;
        if (g < 0) begin
            g = 0;
        end
        if (g > GAIN_TOP) begin
            g = GAIN_TOP;
        end
        gain_q = g;
        prod = (longint'(smp) * g + (longint'(1) <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
        if (prod > CLIP_LIMIT) begin
            prod = CLIP_LIMIT;
        end
        if (prod < -CLIP_LIMIT) begin
            prod = -CLIP_LIMIT;
        end
        return SAMPLE_W'(prod);
    endfunction

    // entered and left at a falling edge
    task automatic send_item(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic                       play,
        input logic [VOL_W-1:0]           vol,
        input logic                       known,
        input logic signed [SAMPLE_W-1:0] want
    );
        logic signed [SAMPLE_W-1:0] predicted;
        while (!steady && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_in    <= smp;
        s_play_enable  <= play;
        s_volume_level <= vol;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = gain_scaled_sample(smp, play, vol);
        pending_samples.push_back('{items_sent, known ? want : predicted});
        if (gain_q > peak_gain) begin
            peak_gain = gain_q;
        end
        items_sent++;
        if (!play) begin
            paused_items++;
        end
        if (vol > VOL_MAX) begin
            saturated_vol++;
        end
        @(negedge aclk);
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] smp;
        logic                       play;
        logic [VOL_W-1:0]           vol;
        int                         pick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_sample_in    = '0;
        s_play_enable  = 1'b0;
        s_volume_level = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].smp, dir_tab[i].play, dir_tab[i].vol,
                      dir_tab[i].known, dir_tab[i].want);
        end

        // loud stretch ramps the gain well up toward full scale, then anything goes
        for (int n = 0; n < LOUD_ITEMS + MIXED_ITEMS; n++) begin
            steady = (n >= 500 && n < 700);
            if (n == 400) begin
                hold_req = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 30) begin
                smp = SAMPLE_W'($urandom_range(8388607, 7700000));
                if ($urandom_range(1)) begin
                    smp = -smp;
                end
            end else if (pick < 40) begin
                smp = SAMPLE_W'(int'($urandom_range(255)) - 128);
            end else begin
                smp = SAMPLE_W'($urandom());
            end
            if (n < LOUD_ITEMS) begin
                play = $urandom_range(99) < 97;
                vol  = ($urandom_range(99) < 70) ? VOL_W'(VOL_MAX)
                                                 : VOL_W'($urandom_range(127, 101));
            end else begin
                play = $urandom_range(99) < 80;
                vol  = VOL_W'($urandom_range(127));
            end
            send_item(smp, play, vol, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d items (%0d paused, %0d with volume above 100), %0d results",
                 items_sent, paused_items, saturated_vol, results_seen);
        $display("%0d results at the clip limit, peak gain %0d percent",
                 clipped_results, peak_gain * 100 / GAIN_ONE);
        if (errors == 0) begin
            $display("** audio_gain_ramp_clipper_top: PASSED **");
        end else begin
            $display("** audio_gain_ramp_clipper_top: FAILED **");
        end
        $finish;
    end

    // result side, with one long hold-off so the output register backs up
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_sample_out == CLIP_LIMIT || m_sample_out == -CLIP_LIMIT) begin
                clipped_results++;
            end
            if (pending_samples.size() == 0) begin
                flag_error($sformatf("unexpected result sample_out=%0d", m_sample_out));
            end else begin
                head_exp = pending_samples.pop_front();
                if (m_sample_out !== head_exp.smp) begin
                    flag_error($sformatf("item %0d: sample_out=%0d, wanted %0d",
                                         head_exp.idx, m_sample_out, head_exp.smp));
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("timeout with %0d results still outstanding", pending_samples.size());
        $display("** audio_gain_ramp_clipper_top: FAILED **");
        $finish;
    end

endmodule
